// ===== rtl/lteb_pkg.sv =====
// ----------------------------------------------------------------------------
// lteb_pkg
// Shared types and constants for the list-mode timestamp event builder.
// ----------------------------------------------------------------------------
package lteb_pkg;

    localparam int NumSlots   = 10;
    localparam int SlotW      = 4;
    localparam int StampW     = 48;
    localparam int LowW       = 28;
    localparam int UpperW     = StampW - LowW;
    localparam int ValueW     = 16;
    localparam int IdentW     = 12;

    localparam logic [31:0] PadZero  = 32'h0000_0000;
    localparam logic [31:0] PadFill  = 32'h5e5e_5e5e;
    localparam logic [31:0] PadOnes  = 32'hffff_ffff;
    localparam logic [31:0] SyncMask = 32'hc0f0_0000;
    localparam logic [31:0] SyncCode = 32'h8040_0000;
    localparam logic [1:0]  DataType = 2'b11;

    localparam logic [LowW-1:0]   WrapLimit = 28'h000_001a;
    localparam logic [6:0]        VetoCard  = 7'd99;
    localparam logic [2:0]        VetoFine  = 3'b111;

    localparam logic [IdentW-1:0] SlowFirst = 12'd64;
    localparam logic [IdentW-1:0] SlowLast  = 12'd67;
    localparam logic [IdentW-1:0] FastFirst = 12'd88;
    localparam logic [IdentW-1:0] FastLast  = 12'd92;
    localparam logic [IdentW-1:0] FastBase  = 12'd84;
    localparam logic [IdentW-1:0] AuxIdent  = 12'd95;
    localparam logic [SlotW-1:0]  AuxSlot   = 4'd9;
    localparam logic [SlotW-1:0]  LastSlot  = 4'(NumSlots - 1);

    typedef struct packed {
        logic [31:0] word_low;
        logic [31:0] word_high;
    } t_in_word;

    typedef struct packed {
        logic [SlotW-1:0]  slot;
        logic              filled;
        logic [StampW-1:0] stamp;
        logic [ValueW-1:0] value;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic             load;
        logic             decode;
        logic             capture_now;
        logic             capture_held;
        logic             take;
        logic [SlotW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic flush;
    } t_sts;

endpackage

// ===== rtl/lteb_ctrl.sv =====
// ----------------------------------------------------------------------------
// lteb_ctrl
// Sequencer: load word, decode, drain the ten slots on an event flush.
// ----------------------------------------------------------------------------
module lteb_ctrl import lteb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [SlotW-1:0] r_cnt, n_cnt;
    logic             w_take;
    logic             w_end;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_EMIT);
    assign w_take      = o_out_valid && !i_out_stall;
    assign w_end       = w_take && (r_cnt == LastSlot);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_cnt = '0;
                if (i_sts.flush) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_take) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (w_end) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd              = '0;
        o_cmd.load         = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.decode       = (r_state == ST_DECODE);
        o_cmd.capture_now  = (r_state == ST_DECODE) && !i_sts.flush;
        o_cmd.capture_held = w_end;
        o_cmd.take         = w_take;
        o_cmd.idx          = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/lteb_datapath.sv =====
// ----------------------------------------------------------------------------
// lteb_datapath
// Word decode, timestamp rebuild, slot store and output selection.
// ----------------------------------------------------------------------------
module lteb_datapath import lteb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_word,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_word o_word
);

    t_in_word          r_in;
    logic [StampW-1:0] r_cur;
    logic [StampW-1:0] r_prev;
    logic              r_wrap;
    logic [StampW-1:0] r_ts;
    logic [SlotW-1:0]  r_sidx;
    logic              r_hit;

    logic              r_slot_valid [NumSlots];
    logic [StampW-1:0] r_slot_stamp [NumSlots];
    logic [ValueW-1:0] r_slot_value [NumSlots];

    logic              w_pad, w_data, w_sync, w_wrap_now;
    logic [IdentW-1:0] w_ident;
    logic [ValueW-1:0] w_val;
    logic [LowW-1:0]   w_low;
    logic [StampW-1:0] w_ts;
    logic              w_veto, w_hit;
    logic [SlotW-1:0]  w_sidx;
    logic              w_cap;
    logic [SlotW-1:0]  w_cap_idx;
    logic [StampW-1:0] w_cap_ts;
    logic [ValueW-1:0] w_cap_val;
    logic [ValueW-1:0] r_hval;

    always_comb begin
        w_pad = ((r_in.word_low == PadZero) && (r_in.word_high == PadZero)) ||
                ((r_in.word_low == PadFill) &&
                 ((r_in.word_high == PadFill) || (r_in.word_high == PadOnes)));
        w_ident = r_in.word_high[27:16];
        w_val   = r_in.word_high[15:0];
        w_low   = r_in.word_low[LowW-1:0];
        w_data  = !w_pad && (r_in.word_high[31:30] == DataType) &&
                  (w_ident[IdentW-1:5] != VetoCard);
        w_sync  = !w_pad && (r_in.word_high[31:30] != DataType) &&
                  ((r_in.word_high & SyncMask) == SyncCode);
        w_wrap_now = (w_low <= WrapLimit) && !r_wrap;
        if (w_wrap_now) begin
            w_ts = {r_cur[StampW-1:LowW] + 1'b1, w_low};
        end else begin
            w_ts = {r_cur[StampW-1:LowW], w_low};
        end
        w_veto = (w_val[15:13] == VetoFine);
        w_hit  = 1'b0;
        w_sidx = '0;
        if ((w_ident >= SlowFirst) && (w_ident <= SlowLast)) begin
            w_hit  = !w_veto;
            w_sidx = SlotW'(w_ident - SlowFirst);
        end else if ((w_ident >= FastFirst) && (w_ident <= FastLast)) begin
            w_hit  = !w_veto;
            w_sidx = SlotW'(w_ident - FastBase);
        end else if (w_ident == AuxIdent) begin
            w_hit  = 1'b1;
            w_sidx = AuxSlot;
        end
        w_hit = w_hit && w_data;
    end

    assign o_sts.flush = w_data && (w_ts > r_prev);

    always_comb begin
        w_cap     = 1'b0;
        w_cap_idx = r_sidx;
        w_cap_ts  = r_ts;
        w_cap_val = r_hval;
        if (i_cmd.capture_now) begin
            w_cap     = w_hit && !r_slot_valid[w_sidx];
            w_cap_idx = w_sidx;
            w_cap_ts  = w_ts;
            w_cap_val = w_val;
        end else if (i_cmd.capture_held) begin
            w_cap = r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_word;
        end
        if (i_cmd.decode) begin
            r_ts   <= w_ts;
            r_sidx <= w_sidx;
            r_hval <= w_val;
        end
        for (int i = 0; i < NumSlots; i++) begin
            if (w_cap && (w_cap_idx == SlotW'(i))) begin
                r_slot_stamp[i] <= w_cap_ts;
                r_slot_value[i] <= w_cap_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_prev <= '0;
            r_wrap <= 1'b0;
            r_hit  <= 1'b0;
            for (int i = 0; i < NumSlots; i++) begin
                r_slot_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cmd.decode) begin
                r_hit <= w_hit;
                if (w_data) begin
                    r_cur  <= w_ts;
                    r_prev <= w_ts;
                    if (w_wrap_now) begin
                        r_wrap <= 1'b1;
                    end
                end else if (w_sync) begin
                    r_cur  <= {r_in.word_high[UpperW-1:0], w_low};
                    r_wrap <= 1'b0;
                end
            end
            for (int i = 0; i < NumSlots; i++) begin
                if (i_cmd.take && (i_cmd.idx == SlotW'(i))) begin
                    r_slot_valid[i] <= 1'b0;
                end
                if (w_cap && (w_cap_idx == SlotW'(i))) begin
                    r_slot_valid[i] <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_word        = '0;
        o_word.slot   = i_cmd.idx;
        o_word.filled = r_slot_valid[i_cmd.idx];
        o_word.stamp  = r_slot_valid[i_cmd.idx] ? r_slot_stamp[i_cmd.idx] : '0;
        o_word.value  = r_slot_valid[i_cmd.idx] ? r_slot_value[i_cmd.idx] : '0;
        o_word.last   = (i_cmd.idx == LastSlot);
    end

endmodule

// ===== rtl/listmode_timestamp_event_builder_core.sv =====
// ----------------------------------------------------------------------------
// listmode_timestamp_event_builder_core
// Each word is loaded, then decoded; a flush adds 10 output words.
// The input stalls until a word is done; a flush is drained by the single
// output port, one slot per cycle while the output is not stalled.
// Reset: synchronous, active low; clears timestamps, wrap flag and all slots.
// ----------------------------------------------------------------------------
module listmode_timestamp_event_builder_core import lteb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_cmd w_cmd;
    t_sts w_sts;

    lteb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lteb_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_in_word),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_word  (o_out_word)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the list-mode timestamp event builder. Words are
// driven over the valid/stall input channel; an in-bench model of the
// timestamp rebuild and slot capture queues the ten slot words of every
// flushed event, and each slot word leaving the block is checked against it.
// Directed words cover padding, dropped cards, vetoes and timestamp wrap;
// random events follow under varying idle patterns and a long output hold.
// ----------------------------------------------------------------------------
module tb_top;
    import lteb_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 400;

    logic      i_clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      out_hold  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    int send_idle_pct = 33;
    int recv_idle_pct = 52;
    int err_count     = 0;
    int words_sent    = 0;
    int slots_seen    = 0;
    int cycle_count   = 0;

    // builder state as the bench sees it
    logic [StampW-1:0] now_stamp       = '0;
    logic [StampW-1:0] last_data_stamp = '0;
    logic              wrap_taken      = 1'b0;
    logic              held_full  [NumSlots];
    logic [StampW-1:0] held_stamp [NumSlots];
    logic [ValueW-1:0] held_value [NumSlots];
    t_out_word         expected_slots[$];

    logic [LowW-1:0] stim_low = '0;

    listmode_timestamp_event_builder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < NumSlots; k++) begin
            held_full[k]  = 1'b0;
            held_stamp[k] = '0;
            held_value[k] = '0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_stall <= out_hold || ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    task automatic predict_event_slots(input t_in_word w);
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [LowW-1:0]   low28;
        logic [IdentW-1:0] ident;
        logic [ValueW-1:0] val;
        logic [StampW-1:0] ts;
        int                s;
        t_out_word         r;
        lo    = w.word_low;
        hi    = w.word_high;
        low28 = lo[LowW-1:0];
        if (lo == PadZero && hi == PadZero)
            return;
        if (lo == PadFill && (hi == PadFill || hi == PadOnes))
            return;
        if (hi[31:30] == DataType) begin
            ident = hi[27:16];
            val   = hi[15:0];
            if (ident[IdentW-1:5] == VetoCard)
                return;
            ts = {now_stamp[StampW-1:LowW], low28};
            if (low28 <= WrapLimit && !wrap_taken) begin
                ts = ts + (StampW'(1) << LowW);
                wrap_taken = 1'b1;
            end
            now_stamp = ts;
            if (ts > last_data_stamp) begin
                for (int k = 0; k < NumSlots; k++) begin
                    r.slot   = SlotW'(k);
                    r.filled = held_full[k];
                    r.stamp  = held_full[k] ? held_stamp[k] : '0;
                    r.value  = held_full[k] ? held_value[k] : '0;
                    r.last   = (SlotW'(k) == LastSlot);
                    expected_slots = {expected_slots, r};
                    held_full[k]  = 1'b0;
                    held_stamp[k] = '0;
                    held_value[k] = '0;
                end
            end
            s = -1;
            if (ident >= SlowFirst && ident <= SlowLast) begin
                if (val[15:13] != VetoFine)
                    s = int'(ident - SlowFirst);
            end else if (ident >= FastFirst && ident <= FastLast) begin
                if (val[15:13] != VetoFine)
                    s = int'(ident - FastBase);
            end else if (ident == AuxIdent) begin
                s = int'(AuxSlot);
            end
            if (s >= 0 && !held_full[s]) begin
                held_full[s]  = 1'b1;
                held_stamp[s] = ts;
                held_value[s] = val;
            end
            last_data_stamp = ts;
        end else if ((hi & SyncMask) == SyncCode) begin
            now_stamp  = {hi[UpperW-1:0], low28};
            wrap_taken = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("mismatch on %s: got %0h, wanted %0h", what, got, want);
    endtask

    task automatic check_slot_word(input t_out_word got);
        t_out_word want;
        slots_seen++;
        if (expected_slots.size() == 0) begin
            report_mismatch("unexpected slot word, slot", 64'(got.slot), 64'(0));
            return;
        end
        want = expected_slots.pop_front();
        if (got.slot != want.slot)
            report_mismatch("slot", 64'(got.slot), 64'(want.slot));
        if (got.filled != want.filled)
            report_mismatch("filled", 64'(got.filled), 64'(want.filled));
        if (got.stamp != want.stamp)
            report_mismatch("stamp", 64'(got.stamp), 64'(want.stamp));
        if (got.value != want.value)
            report_mismatch("value", 64'(got.value), 64'(want.value));
        if (got.last != want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
    endtask

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall)
            check_slot_word(o_out_word);
    end

    // ------------------------------------------------------------------------
    // word builders and driver
    // ------------------------------------------------------------------------
    function automatic t_in_word data_word(input logic [LowW-1:0] low,
                                           input logic [IdentW-1:0] ident,
                                           input logic [ValueW-1:0] val);
        t_in_word w;
        w.word_low  = {4'($urandom), low};
        w.word_high = {DataType, 2'($urandom), ident, val};
        return w;
    endfunction

    function automatic t_in_word sync_word(input logic [UpperW-1:0] upper,
                                           input logic [LowW-1:0] low);
        t_in_word w;
        w.word_low  = {4'($urandom), low};
        w.word_high = ($urandom & ~SyncMask & 32'hfff0_0000) | SyncCode | 32'(upper);
        return w;
    endfunction

    function automatic t_in_word noise_word();
        t_in_word   w;
        logic [3:0] nib;
        w.word_low = $urandom;
        case ($urandom_range(4))
            0: w = '{word_low: PadZero, word_high: PadZero};
            1: w = '{word_low: PadFill, word_high: PadFill};
            2: w = '{word_low: PadFill, word_high: PadOnes};
            3: w.word_high = {1'b0, 31'($urandom)};
            default: begin
                nib = 4'($urandom);
                if (nib == SyncCode[23:20])
                    nib = nib + 4'd1;
                w.word_high = {2'b10, 6'($urandom), nib, 20'($urandom)};
            end
        endcase
        return w;
    endfunction

    function automatic logic [IdentW-1:0] pick_ident();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return SlowFirst + IdentW'($urandom_range(3));
        else if (r < 60)
            return FastFirst + IdentW'($urandom_range(4));
        else if (r < 72)
            return AuxIdent;
        else if (r < 78)
            return {VetoCard, 5'($urandom)};
        else if (r < 90)
            return IdentW'($urandom);
        else
            case ($urandom_range(5))
                0: return SlowFirst - 12'd1;
                1: return SlowLast + 12'd1;
                2: return FastFirst - 12'd1;
                3: return FastLast + 12'd1;
                4: return AuxIdent - 12'd1;
                default: return AuxIdent + 12'd1;
            endcase
    endfunction

    task automatic send_word(input t_in_word w);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_event_slots(w);
        words_sent++;
    endtask

    task automatic advance_stim_low();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            stim_low = LowW'($urandom_range(0, int'(WrapLimit)));
        else if (r < 12)
            stim_low = LowW'($urandom);
        else
            stim_low = stim_low + LowW'($urandom_range(1, 4096));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_dropped_words();
        send_word('{word_low: PadZero, word_high: PadZero});
        send_word('{word_low: PadFill, word_high: PadFill});
        send_word('{word_low: PadFill, word_high: PadOnes});
        send_word('{word_low: $urandom, word_high: {2'b01, 30'($urandom)}});
        send_word('{word_low: $urandom, word_high: {2'b10, 6'h3f, 4'hf, 20'hfffff}});
        // card 99 must not touch the wrap flag or the timestamp
        send_word(data_word(28'h5, {VetoCard, 5'h1f}, 16'hffff));
    endtask

    task automatic test_slot_capture();
        send_word(sync_word(20'h00001, 28'h100));
        send_word(data_word(28'h200, SlowFirst, 16'h1234));
        send_word(data_word(28'h200, SlowLast, 16'he000));
        send_word(data_word(28'h200, SlowLast, 16'hdfff));
        send_word(data_word(28'h200, FastFirst, 16'h0000));
        send_word(data_word(28'h200, FastLast, 16'h1fff));
        send_word(data_word(28'h200, AuxIdent, 16'hffff));
        send_word(data_word(28'h200, SlowFirst, 16'haaaa));
        send_word(data_word(28'h200, 12'd100, 16'h5555));
        send_word(data_word(28'h200, 12'hfff, 16'h0000));
        send_word(data_word(28'h200, 12'h000, 16'hffff));
        send_word(data_word(28'h300, FastFirst + 12'd2, 16'h0001));
    endtask

    task automatic test_stamp_rebuild();
        send_word(sync_word(20'hfffff, 28'hffffff0));
        send_word(data_word(28'hffffff0, FastFirst + 12'd1, 16'h4321));
        // wrap bump rolls the 48-bit stamp over to a small value
        send_word(data_word(28'h5, FastFirst + 12'd3, 16'h0bad));
        send_word(data_word(WrapLimit, SlowFirst + 12'd1, 16'h0042));
        send_word(data_word(28'hfffffff, SlowFirst + 12'd2, 16'hc0de));
        send_word(sync_word(20'h12345, 28'h0));
        send_word(data_word(WrapLimit, AuxIdent, 16'hf00d));
        send_word(data_word(WrapLimit + 28'd1, SlowFirst, 16'h0001));
    endtask

    task automatic test_random_events(input int n_words, input int snd_pct,
                                      input int rcv_pct);
        int sent;
        int hits;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n_words) begin
            case ($urandom_range(19))
                0: begin
                    send_word(sync_word(20'($urandom), stim_low));
                    sent++;
                end
                1: send_word(noise_word());
                2: begin
                    send_word(data_word(stim_low - LowW'($urandom_range(1, 64)),
                                        pick_ident(), 16'($urandom)));
                    sent++;
                end
                default: begin
                    advance_stim_low();
                    hits = $urandom_range(1, 6);
                    repeat (hits) begin
                        send_word(data_word(stim_low, pick_ident(), 16'($urandom)));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                out_hold <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
                out_hold <= 1'b0;
            end
        join_none
        repeat (30) begin
            stim_low = stim_low + LowW'($urandom_range(64, 255));
            send_word(data_word(stim_low, SlowFirst + IdentW'($urandom_range(3)),
                                16'($urandom)));
            send_word(data_word(stim_low, AuxIdent, 16'($urandom)));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_dropped_words();
        test_slot_capture();
        test_stamp_rebuild();
        test_random_events(60, 33, 52);
        test_random_events(60, 52, 33);
        test_back_pressure();
        test_random_events(60, 0, 0);
        in_valid <= 1'b0;
        while (expected_slots.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d input words and %0d slot words: padding, card 99, vetoes,",
                 words_sent, slots_seen);
        $display("occupied slots, sync and stamp wrap, random idling and a long output hold");
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lteb_pkg.sv
rtl/lteb_ctrl.sv
rtl/lteb_datapath.sv
rtl/listmode_timestamp_event_builder_core.sv
tb/sv/tb_top.sv
